// ----- sv/md5_digest_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// md5_digest_engine_core_assert.svh
// Assertion macros used by the digest engine checker.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_ENGINE_CORE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define MD5DE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("md5de: same-cycle check failed");

// next-cycle implication
`define MD5DE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("md5de: next-cycle check failed");

`endif

// ----- sv/md5de_pkg.sv -----
// ----------------------------------------------------------------------------
// md5de_pkg
// Types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5de_pkg;

	localparam int BLK_WORDS = 16;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] chain_t;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} out_beat_t;

	typedef struct packed {
		logic       take_byte;
		logic       wr_pad;
		logic       wr_zero;
		logic [3:0] zero_addr;
		logic       wr_len_lo;
		logic       wr_len_hi;
		logic       rnd_load;
		logic       rnd_step;
		logic [5:0] rnd_idx;
		logic [5:0] rd_idx;
		logic       fin_chain;
		logic       fin_digest;
	} cmd_t;

	typedef struct packed {
		logic       fill_full;
		logic       fill_ovf;
		logic [3:0] pad_word;
		logic       out_busy;
	} sts_t;

	localparam chain_t     IV           = {32'h10325476, 32'h98badcfe,
	                                       32'hefcdab89, 32'h67452301};
	localparam logic [7:0] PAD_BYTE     = 8'h80;
	localparam logic [3:0] LEN_LO_WORD  = 4'd14;
	localparam logic [3:0] LEN_HI_WORD  = 4'd15;
	localparam logic [4:0] ZERO_END_LEN = 5'd14;
	localparam logic [4:0] ZERO_END_BLK = 5'd16;
	localparam logic [5:0] FILL_LAST    = 6'd63;
	localparam logic [5:0] FILL_OVF     = 6'd56;
	localparam logic [1:0] LAST_INDEX   = 2'd3;
	localparam logic [1:0] BYTE_TOP     = 2'd3;
	localparam logic [6:0] ROUND_END    = 7'd64;

	function automatic word_t md5_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	// message word schedule, mod 16
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0:    g = i[3:0];
			2'd1:    g = i[3:0] * 4'd5 + 4'd1;
			2'd2:    g = i[3:0] * 4'd3 + 4'd5;
			default: g = i[3:0] * 4'd7;
		endcase
		return g;
	endfunction

endpackage

// ----- sv/md5_digest_engine_core.sv -----
// ----------------------------------------------------------------------------
// md5_digest_engine_core
// MD5 over a byte stream with built-in padding; emits h0..h3 per message.
//
//   channel  signals                        beat
//   in       in_valid in_ready in_data      one message byte and/or end mark
//   out      out_valid out_ready out_data   one digest word, index 0..3
//
// The byte that completes a 64-byte block adds a compression (load, 64
// rounds at one round per cycle, chaining add). End of message adds pad,
// zero-fill, two length words and compression; when the length spills over,
// pad, zero-fill, compression, zero-fill, two length words, compression.
// The final add waits for the previous digest to drain; no clearing pass
// after reset. A new message streams in while the four output words drain.
// ----------------------------------------------------------------------------
module md5_digest_engine_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  md5de_pkg::in_beat_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output md5de_pkg::out_beat_t  out_data
);
	import md5de_pkg::*;

	cmd_t cmd;
	sts_t sts;

	md5de_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.sts      (sts),
		.cmd      (cmd)
	);

	md5de_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ----- sv/md5de_ram.sv -----
// ----------------------------------------------------------------------------
// md5de_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module md5de_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/md5de_datapath.sv -----
// ----------------------------------------------------------------------------
// md5de_datapath
// Block buffer, byte packing, padding words, round unit, chaining words and
// digest output register.
// ----------------------------------------------------------------------------
module md5de_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md5de_pkg::in_beat_t   in_data,
	input  md5de_pkg::cmd_t       cmd,
	output md5de_pkg::sts_t       sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output md5de_pkg::out_beat_t  out_data
);
	import md5de_pkg::*;

	logic [5:0]  fill_q;
	logic [63:0] bit_len_q;
	logic [23:0] acc_q;
	chain_t      chain_q;
	chain_t      dig_q;
	chain_t      sum_w;
	word_t       a_q, b_q, c_q, d_q;
	logic        out_valid_q;
	logic [1:0]  oidx_q;

	logic        byte_in;
	logic        ram_we;
	logic [3:0]  ram_waddr;
	word_t       ram_wdata;
	word_t       ram_rdata;
	word_t       pad_w;
	word_t       src_w;
	word_t       f_w;
	word_t       t_w;
	logic [63:0] rot_w;
	word_t       b_new;

	assign byte_in = cmd.take_byte && in_data.has_byte;

	// pad word: bytes so far, then 0x80, then zeros
	always_comb begin
		src_w = {8'h00, acc_q};
		pad_w = '0;
		for (int j = 0; j < 4; j++) begin
			if (2'(j) < fill_q[1:0]) begin
				pad_w[8*j +: 8] = src_w[8*j +: 8];
			end else if (2'(j) == fill_q[1:0]) begin
				pad_w[8*j +: 8] = PAD_BYTE;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q[5:2];
		ram_wdata = '0;
		if (byte_in && fill_q[1:0] == BYTE_TOP) begin
			ram_we    = 1'b1;
			ram_wdata = {in_data.msg_byte, acc_q};
		end else if (cmd.wr_pad) begin
			ram_we    = 1'b1;
			ram_wdata = pad_w;
		end else if (cmd.wr_zero) begin
			ram_we    = 1'b1;
			ram_waddr = cmd.zero_addr;
		end else if (cmd.wr_len_lo) begin
			ram_we    = 1'b1;
			ram_waddr = LEN_LO_WORD;
			ram_wdata = bit_len_q[31:0];
		end else if (cmd.wr_len_hi) begin
			ram_we    = 1'b1;
			ram_waddr = LEN_HI_WORD;
			ram_wdata = bit_len_q[63:32];
		end
	end

	md5de_ram #(
		.WIDTH(32),
		.DEPTH(BLK_WORDS)
	) u_blk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (md5_g(cmd.rd_idx)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			bit_len_q <= '0;
		end else if (cmd.fin_digest) begin
			fill_q    <= '0;
			bit_len_q <= '0;
		end else if (byte_in) begin
			fill_q    <= fill_q + 6'd1;
			bit_len_q <= bit_len_q + 64'd8;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in && fill_q[1:0] != BYTE_TOP) begin
			acc_q[8*fill_q[1:0] +: 8] <= in_data.msg_byte;
		end
	end

	// one MD5 round
	always_comb begin
		case (cmd.rnd_idx[5:4])
			2'd0:    f_w = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f_w = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f_w = b_q ^ c_q ^ d_q;
			default: f_w = c_q ^ (b_q | ~d_q);
		endcase
		t_w   = f_w + a_q + md5_k(cmd.rnd_idx) + ram_rdata;
		rot_w = {t_w, t_w} << md5_rot(cmd.rnd_idx);
		b_new = b_q + rot_w[63:32];
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd_load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (cmd.rnd_step) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_comb begin
		sum_w[0] = chain_q[0] + a_q;
		sum_w[1] = chain_q[1] + b_q;
		sum_w[2] = chain_q[2] + c_q;
		sum_w[3] = chain_q[3] + d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV;
		end else if (cmd.fin_digest) begin
			chain_q <= IV;
		end else if (cmd.fin_chain) begin
			chain_q <= sum_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_digest) begin
			dig_q <= sum_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			oidx_q      <= '0;
		end else if (cmd.fin_digest) begin
			out_valid_q <= 1'b1;
			oidx_q      <= '0;
		end else if (out_valid_q && out_ready) begin
			if (oidx_q == LAST_INDEX) begin
				out_valid_q <= 1'b0;
			end
			oidx_q <= oidx_q + 2'd1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.digest_word = dig_q[oidx_q];
		out_data.word_index  = oidx_q;
		out_data.last_word   = (oidx_q == LAST_INDEX);
	end

	always_comb begin
		sts.fill_full = (fill_q == FILL_LAST);
		sts.fill_ovf  = (fill_q >= FILL_OVF);
		sts.pad_word  = fill_q[5:2];
		sts.out_busy  = out_valid_q;
	end

endmodule

// ----- sv/md5de_ctrl.sv -----
// ----------------------------------------------------------------------------
// md5de_ctrl
// Sequencer: byte intake, padding sweep, length words, round count and
// finalization.
// ----------------------------------------------------------------------------
module md5de_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  md5de_pkg::in_beat_t in_data,
	input  md5de_pkg::sts_t     sts,
	output md5de_pkg::cmd_t     cmd
);
	import md5de_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ZERO,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_COMP,
		ST_FIN
	} state_t;

	state_t     state_q;
	logic       eom_q;
	logic       ovf_q;
	logic       last_q;
	logic [6:0] rnd_q;
	logic [4:0] zptr_q;
	logic       in_fire;
	logic       zero_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign zero_done = (zptr_q >= (ovf_q ? ZERO_END_BLK : ZERO_END_LEN));

	always_comb begin
		cmd            = '0;
		cmd.take_byte  = in_fire;
		cmd.wr_pad     = (state_q == ST_PAD);
		cmd.wr_zero    = (state_q == ST_ZERO) && !zero_done;
		cmd.zero_addr  = zptr_q[3:0];
		cmd.wr_len_lo  = (state_q == ST_LEN_LO);
		cmd.wr_len_hi  = (state_q == ST_LEN_HI);
		cmd.rnd_load   = (state_q == ST_COMP) && (rnd_q == '0);
		cmd.rnd_step   = (state_q == ST_COMP) && (rnd_q != '0);
		cmd.rnd_idx    = rnd_q[5:0] - 6'd1;
		cmd.rd_idx     = rnd_q[5:0];
		cmd.fin_chain  = (state_q == ST_FIN) && !last_q;
		cmd.fin_digest = (state_q == ST_FIN) && last_q && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eom_q   <= 1'b0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			rnd_q   <= '0;
			zptr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						eom_q <= in_data.end_of_message;
						if (in_data.has_byte && sts.fill_full) begin
							state_q <= ST_COMP;
						end else if (in_data.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					zptr_q  <= {1'b0, sts.pad_word} + 5'd1;
					ovf_q   <= sts.fill_ovf;
					state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					if (zero_done) begin
						state_q <= ovf_q ? ST_COMP : ST_LEN_LO;
					end else begin
						zptr_q <= zptr_q + 5'd1;
					end
				end
				ST_LEN_LO: begin
					state_q <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					last_q  <= 1'b1;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (rnd_q == ROUND_END) begin
						rnd_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_FIN: begin
					if (last_q) begin
						if (!sts.out_busy) begin
							last_q  <= 1'b0;
							eom_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else if (ovf_q) begin
						// length goes in a second padding block
						ovf_q   <= 1'b0;
						zptr_q  <= '0;
						state_q <= ST_ZERO;
					end else if (eom_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/md5de_checker.sv -----
// ----------------------------------------------------------------------------
// md5de_checker
// Port-level checks of the digest output sequence, bound to the top level.
// ----------------------------------------------------------------------------
`include "md5_digest_engine_core_assert.svh"

module md5de_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input md5de_pkg::in_beat_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input md5de_pkg::out_beat_t out_data
);
	import md5de_pkg::*;

	logic in_fire;

	assign in_fire = in_valid && in_ready && in_data.has_byte;

	`MD5DE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`MD5DE_ASSERT_IMP(a_last_tag, clk, arst_n, out_valid || in_fire, !out_valid || (out_data.last_word == (out_data.word_index == LAST_INDEX)))
	`MD5DE_ASSERT_NXT(a_word_seq, clk, arst_n, out_valid && out_ready && !out_data.last_word, out_valid && (out_data.word_index == $past(out_data.word_index) + 2'd1))
	`MD5DE_ASSERT_IMP(a_first_word, clk, arst_n, $rose(out_valid), out_data.word_index == 2'd0)

endmodule

bind md5_digest_engine_core md5de_checker u_md5de_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for md5_digest_engine_core. Byte beats are streamed
// as whole messages with random content and lengths, some spanning block
// boundaries. Random gaps on the input side and random stalls on the digest
// side are applied. A scoreboard class runs its own MD5 over every accepted
// beat and checks each digest word in order.
// ----------------------------------------------------------------------------
import md5de_pkg::*;

class md5_scoreboard;
	bit [31:0]  chain[4];
	bit [7:0]   blk[64];
	bit [5:0]   fill;
	bit [63:0]  nbits;
	bit [31:0]  kt[64];
	int         shifts[16];
	out_beat_t  digests[$];
	int         mismatches;
	int         words_checked;

	function new();
		real v;
		shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		for (int i = 0; i < 64; i++) begin
			v = $sin(i + 1);
			if (v < 0.0)
				v = -v;
			kt[i] = 32'(longint'($floor(v * 4294967296.0)));
		end
		mismatches = 0;
		words_checked = 0;
		restart();
	endfunction

	function void restart();
		chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
		fill = '0;
		nbits = '0;
	endfunction

	function void compress();
		bit [31:0] a, b, c, d, f, t, m;
		int g, s, i;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (d & b) | (~d & c); g = 5 * i + 1; end
				2: begin f = b ^ c ^ d; g = 3 * i + 5; end
				default: begin f = c ^ (b | ~d); g = 7 * i; end
			endcase
			g = g % 16;
			m = {blk[4 * g + 3], blk[4 * g + 2], blk[4 * g + 1], blk[4 * g]};
			t = f + a + kt[i] + m;
			s = shifts[(i / 16) * 4 + i % 4];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	function void note_input(in_beat_t beat);
		out_beat_t w;
		int i;
		if (beat.has_byte) begin
			blk[fill] = beat.msg_byte;
			nbits += 64'd8;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress();
		end
		if (!beat.end_of_message)
			return;
		blk[fill] = 8'h80;
		for (i = int'(fill) + 1; i < 64; i++)
			blk[i] = '0;
		if (fill >= 6'd56) begin
			compress();
			for (i = 0; i < 64; i++)
				blk[i] = '0;
		end
		for (i = 0; i < 8; i++)
			blk[56 + i] = nbits[8 * i +: 8];
		compress();
		for (i = 0; i < 4; i++) begin
			w.digest_word = chain[i];
			w.word_index  = 2'(i);
			w.last_word   = (i == 3);
			digests.push_back(w);
		end
		restart();
	endfunction

	function void check_result(out_beat_t got);
		out_beat_t want;
		if (digests.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected digest beat: word %h index %0d last %b",
					got.digest_word, got.word_index, got.last_word);
			return;
		end
		want = digests.pop_front();
		words_checked++;
		if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
				got.last_word !== want.last_word) begin
			mismatches++;
			if (mismatches <= 10)
				$display("digest mismatch: word %h/%h index %0d/%0d last %b/%b (exp/act)",
					want.digest_word, got.digest_word, want.word_index, got.word_index,
					want.last_word, got.last_word);
		end
	endfunction

	function int pending();
		return digests.size();
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_beat_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_beat_t  out_data;

	md5_scoreboard sb = new();

	int  item_count;
	int  msg_count;
	int  stall_left;
	int  idle_cycles;
	int  cycle_count;
	bit  calm;

	md5_digest_engine_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm <= (cycle_count % 600) >= 450;
	end

	task automatic send_beat(input logic [7:0] b, input logic has, input logic eom);
		in_beat_t beat;
		int gap;
		beat.msg_byte = b;
		beat.has_byte = has;
		beat.end_of_message = eom;
		in_valid <= 1'b1;
		in_data  <= beat;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(beat);
		item_count++;
		if (eom)
			msg_count++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_idle();
		send_beat(8'($urandom), 1'b0, 1'b0);
	endtask

	// random bytes, optional idle noise, end marked on the last byte or bare
	task automatic send_message(input int len);
		bit bare_end;
		bare_end = ($urandom_range(0, 3) == 0) || (len == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_idle();
			send_beat(8'($urandom), 1'b1, !bare_end && (i == len - 1));
		end
		if (bare_end)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 12);
		if (r < 80)
			return $urandom_range(13, 50);
		if (r < 95)
			return $urandom_range(51, 70);
		return $urandom_range(110, 130);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d digest words pending",
					STALL_LIMIT, sb.pending());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int boundary_lens[5];
		item_count  = 0;
		msg_count   = 0;
		stall_left  = 0;
		idle_cycles = 0;
		cycle_count = 0;
		calm        = 1'b0;
		boundary_lens = '{55, 56, 63, 64, 120};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b0);
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'ha5, 1'b0, 1'b1);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h7f, 1'b1, 1'b1);

		foreach (boundary_lens[i])
			send_message(boundary_lens[i]);
		while (item_count < 410)
			send_message(pick_length());
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d beats in %0d messages; %0d digest words compared, %0d mismatches",
			item_count, msg_count, sb.words_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
